[hw/rtl/modulated_delay_chorus_defines.svh]
// assertion macros for the modulated delay chorus
`ifndef MODULATED_DELAY_CHORUS_DEFINES_SVH
`define MODULATED_DELAY_CHORUS_DEFINES_SVH

// same-cycle implication
`define MDC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MDC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/mdc_pkg.sv]
// shared types, constants and sine table for the modulated delay chorus
package mdc_pkg;

  localparam int SAMPLE_W     = 24;
  localparam int PHASE_W      = 32;
  localparam int DEPTH_W      = 20;
  localparam int LEVEL_W      = 17;
  localparam int LFO_W        = 16;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 32;
  localparam int SINE_ENTRIES = 1024;
  localparam int SINE_IDX_W   = 10;
  localparam int SINE_QTR     = SINE_ENTRIES / 4;
  localparam int SINE_Q_W     = 8;
  localparam int TAP_W        = 33;
  localparam int MIX_A_W      = 34;
  localparam int MIX_P_W      = MIX_A_W + LEVEL_W;

  localparam logic [SINE_IDX_W:0]  SINE_HALF = (SINE_IDX_W + 1)'(SINE_ENTRIES / 2);
  localparam logic [SINE_IDX_W:0]  SINE_FULL = (SINE_IDX_W + 1)'(SINE_ENTRIES);
  localparam logic [SINE_IDX_W:0]  SINE_QUAD = (SINE_IDX_W + 1)'(SINE_QTR);
  localparam logic [LFO_W-1:0]     LFO_MID   = 16'h8000;
  localparam logic [LEVEL_W-1:0]   LEVEL_UNITY = 17'h10000;
  localparam logic [PHASE_W-1:0]   PHASE_QUAD  = 32'h4000_0000;

  localparam longint PI_Q30 = 64'sd3373259426;
  localparam longint TAYLOR_DIV [12] = '{6, 20, 42, 72, 110, 156, 210, 272, 342, 420, 506, 600};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLE,
    CFG_PHASE_INC,
    CFG_DEPTH,
    CFG_LEVEL
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LFO,
    ST_DLY,
    ST_ADDR,
    ST_RD0,
    ST_RD1,
    ST_INTERP,
    ST_MUL,
    ST_WAIT,
    ST_MIX,
    ST_OUT
  } mdc_state_t;

  typedef logic [14:0] sine_q_t [SINE_QTR];

  // quarter-wave sine magnitude, 32767 full scale
  function automatic logic [14:0] sine_val(input int q);
    longint x;
    longint term;
    longint sum;
    longint v;
    x = (PI_Q30 * longint'(2 * q)) / SINE_ENTRIES;
    term = x;
    sum = x;
    for (int k = 1; k <= 12; k++) begin
      term = (term * x) >>> 30;
      term = (term * x) >>> 30;
      term = term / TAYLOR_DIV[k-1];
      if ((k & 1) != 0) sum = sum - term;
      else sum = sum + term;
    end
    if (sum < 0) sum = 0;
    v = (sum * 32767 + (longint'(1) <<< 29)) >>> 30;
    if (v > 32767) v = 32767;
    return v[14:0];
  endfunction

  function automatic sine_q_t build_sine_q();
    sine_q_t t;
    for (int i = 0; i < SINE_QTR; i++) t[i] = sine_val(i);
    return t;
  endfunction

  localparam sine_q_t     SINE_Q    = build_sine_q();
  localparam logic [14:0] SINE_PEAK = sine_val(SINE_QTR);

endpackage

[hw/rtl/modulated_delay_chorus.sv]
// when enabled, each sample takes two passes through the shared tap path (sine, delay,
//   two ram reads, interpolation) and the 17-step serial mix multiply; when bypassed it
//   goes straight to output, and a new sample is taken only after the last is in the output register
// reset: synchronous active-low rst_n, then the delay ram is zeroed word by word,
//   during which in_stall stays high; configuration writes are taken throughout
// top level of the lfo modulated delay chorus
`include "modulated_delay_chorus_defines.svh"

module modulated_delay_chorus #(
  parameter int DELAY_LEN = 4096
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [mdc_pkg::SAMPLE_W-1:0]    in_sample_in,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [mdc_pkg::SAMPLE_W-1:0]    out_left_out,
  output logic signed [mdc_pkg::SAMPLE_W-1:0]    out_right_out,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [mdc_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [mdc_pkg::CFG_DATA_W-1:0]         cfg_data
);

  localparam int SW   = mdc_pkg::SAMPLE_W;
  localparam int AW   = $clog2(DELAY_LEN);
  localparam int PW   = AW + 8;
  localparam int DW   = 21;
  localparam int CW   = (PW > DW) ? PW : DW;
  localparam int PRW  = mdc_pkg::LFO_W + mdc_pkg::DEPTH_W;
  localparam int PH_W = mdc_pkg::PHASE_W;
  localparam logic [AW-1:0] LAST_IDX = AW'(DELAY_LEN - 1);
  localparam logic [CW-1:0] DMAX     = CW'((DELAY_LEN - 1) * 256);
  localparam logic [PW:0]   SPAN     = (PW + 1)'(DELAY_LEN * 256);
  localparam logic signed [SW+2:0] SAT_MAX = (SW + 3)'((1 << (SW - 1)) - 1);
  localparam logic signed [SW+2:0] SAT_MIN = -(SW + 3)'(1 << (SW - 1));

  mdc_pkg::mdc_state_t state_r, state_nxt;

  logic [AW-1:0]                   clr_idx_r;
  logic [AW-1:0]                   wi_r;
  logic [PH_W-1:0]                 phase_r;
  logic                            enable_r;
  logic [PH_W-1:0]                 phase_inc_r;
  logic [mdc_pkg::DEPTH_W-1:0]     depth_r;
  logic [mdc_pkg::LEVEL_W-1:0]     level_r;
  logic                            side_r;
  logic signed [SW-1:0]            dry_r;
  logic [PRW-1:0]                  prod_r;
  logic [PW-1:0]                   d_r;
  logic [AW-1:0]                   p0_r;
  logic [AW-1:0]                   p1_r;
  logic [7:0]                      f_r;
  logic [SW-1:0]                   x0_r;
  logic [mdc_pkg::TAP_W-1:0]       tap_l_r;
  logic [mdc_pkg::TAP_W-1:0]       tap_r_r;
  logic [SW-1:0]                   res_l_r;
  logic [SW-1:0]                   res_r_r;
  logic                            out_valid_r;
  logic [SW-1:0]                   out_left_r;
  logic [SW-1:0]                   out_right_r;

  logic                            ram_we;
  logic [AW-1:0]                   ram_waddr;
  logic [SW-1:0]                   ram_wdata;
  logic [AW-1:0]                   ram_raddr;
  logic [SW-1:0]                   ram_rdata;

  logic                            mul_start;
  logic                            busy_l;
  logic                            busy_r;
  logic [mdc_pkg::MIX_P_W-1:0]     mp_l;
  logic [mdc_pkg::MIX_P_W-1:0]     mp_r;
  logic [mdc_pkg::MIX_A_W-1:0]     mix_a_l;
  logic [mdc_pkg::MIX_A_W-1:0]     mix_a_r;
  logic [mdc_pkg::LEVEL_W-1:0]     lv;

  logic [PH_W-1:0]                 sel_phase;
  logic [mdc_pkg::SINE_IDX_W:0]    s_m;
  logic [mdc_pkg::SINE_IDX_W:0]    s_mm;
  logic [mdc_pkg::SINE_IDX_W:0]    s_q;
  logic                            s_neg;
  logic [14:0]                     s_mag;
  logic [mdc_pkg::LFO_W-1:0]       lfo;

  logic [DW-1:0]                   d_raw;
  logic [PW:0]                     rp_w;
  logic [PW:0]                     rp_fix;

  logic [SW:0]                     x_diff;
  logic signed [SW+9:0]            f_prod;
  logic [mdc_pkg::TAP_W-1:0]       tap_nxt;

  logic                            in_acc;
  logic                            out_take;

  // rounding, recombine with dry, saturate
  function automatic logic [SW-1:0] mix_out(input logic [SW-1:0] dry,
                                            input logic [mdc_pkg::MIX_P_W-1:0] p);
    logic [mdc_pkg::MIX_P_W-1:0] pr;
    logic [SW+1:0]               sh;
    logic signed [SW+2:0]        s;
    logic [SW-1:0]               r;
    pr = p + mdc_pkg::MIX_P_W'(1 << 24);
    sh = pr[mdc_pkg::MIX_P_W-1:25];
    s  = $signed({{3{dry[SW-1]}}, dry}) + $signed({sh[SW+1], sh});
    if (s > SAT_MAX) r = SAT_MAX[SW-1:0];
    else if (s < SAT_MIN) r = SAT_MIN[SW-1:0];
    else r = s[SW-1:0];
    return r;
  endfunction

  mdc_ram #(
    .WIDTH (SW),
    .DEPTH (DELAY_LEN)
  ) u_delay_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  mdc_sermul #(
    .WA (mdc_pkg::MIX_A_W),
    .WB (mdc_pkg::LEVEL_W)
  ) u_mul_l (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mix_a_l),
    .b     (lv),
    .busy  (busy_l),
    .prod  (mp_l)
  );

  mdc_sermul #(
    .WA (mdc_pkg::MIX_A_W),
    .WB (mdc_pkg::LEVEL_W)
  ) u_mul_r (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mix_a_r),
    .b     (lv),
    .busy  (busy_r),
    .prod  (mp_r)
  );

  assign in_acc   = in_valid && !in_stall;
  assign out_take = out_valid_r && !out_stall;
  assign cfg_ready = 1'b1;

  // sine lookup with quarter-wave folding
  always_comb begin
    sel_phase = side_r ? (phase_r + mdc_pkg::PHASE_QUAD) : phase_r;
    s_m   = {1'b0, sel_phase[PH_W-1 -: mdc_pkg::SINE_IDX_W]};
    s_neg = (s_m > mdc_pkg::SINE_HALF);
    s_mm  = s_neg ? (mdc_pkg::SINE_FULL - s_m) : s_m;
    s_q   = (s_mm > mdc_pkg::SINE_QUAD) ? (mdc_pkg::SINE_HALF - s_mm) : s_mm;
    s_mag = (s_q == mdc_pkg::SINE_QUAD) ? mdc_pkg::SINE_PEAK
                                        : mdc_pkg::SINE_Q[s_q[mdc_pkg::SINE_Q_W-1:0]];
    lfo   = s_neg ? (mdc_pkg::LFO_MID - {1'b0, s_mag}) : (mdc_pkg::LFO_MID + {1'b0, s_mag});
  end

  // delay, read position and interpolation
  always_comb begin
    d_raw   = DW'(256) + {1'b0, prod_r[PRW-1:16]};
    rp_w    = {1'b0, wi_r, 8'h00} + SPAN - {1'b0, d_r};
    rp_fix  = (rp_w >= SPAN) ? (rp_w - SPAN) : rp_w;
    x_diff  = {ram_rdata[SW-1], ram_rdata} - {x0_r[SW-1], x0_r};
    f_prod  = $signed(x_diff) * $signed({1'b0, f_r});
    tap_nxt = {x0_r[SW-1], x0_r, 8'h00} + f_prod[mdc_pkg::TAP_W-1:0];
    lv      = (level_r > mdc_pkg::LEVEL_UNITY) ? mdc_pkg::LEVEL_UNITY : level_r;
    mix_a_l = {tap_l_r, 1'b0} - {{2{dry_r[SW-1]}}, dry_r, 8'h00};
    mix_a_r = {tap_r_r, 1'b0} - {{2{dry_r[SW-1]}}, dry_r, 8'h00};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= mdc_pkg::ST_CLEAR;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    in_stall  = 1'b1;
    ram_we    = 1'b0;
    ram_waddr = wi_r;
    ram_wdata = in_sample_in;
    ram_raddr = p0_r;
    mul_start = 1'b0;
    unique case (state_r)
      mdc_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_idx_r;
        ram_wdata = '0;
        if (clr_idx_r == LAST_IDX) state_nxt = mdc_pkg::ST_IDLE;
      end
      mdc_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (enable_r) begin
            ram_we    = 1'b1;
            state_nxt = mdc_pkg::ST_LFO;
          end else begin
            state_nxt = mdc_pkg::ST_OUT;
          end
        end
      end
      mdc_pkg::ST_LFO:  state_nxt = mdc_pkg::ST_DLY;
      mdc_pkg::ST_DLY:  state_nxt = mdc_pkg::ST_ADDR;
      mdc_pkg::ST_ADDR: state_nxt = mdc_pkg::ST_RD0;
      mdc_pkg::ST_RD0: begin
        ram_raddr = p0_r;
        state_nxt = mdc_pkg::ST_RD1;
      end
      mdc_pkg::ST_RD1: begin
        ram_raddr = p1_r;
        state_nxt = mdc_pkg::ST_INTERP;
      end
      mdc_pkg::ST_INTERP: state_nxt = side_r ? mdc_pkg::ST_MUL : mdc_pkg::ST_LFO;
      mdc_pkg::ST_MUL: begin
        mul_start = 1'b1;
        state_nxt = mdc_pkg::ST_WAIT;
      end
      mdc_pkg::ST_WAIT: begin
        if (!busy_l) state_nxt = mdc_pkg::ST_MIX;
      end
      mdc_pkg::ST_MIX: state_nxt = mdc_pkg::ST_OUT;
      mdc_pkg::ST_OUT: begin
        if (!out_valid_r || !out_stall) state_nxt = mdc_pkg::ST_IDLE;
      end
      default: state_nxt = mdc_pkg::ST_IDLE;
    endcase
  end

  // control state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_idx_r   <= '0;
      wi_r        <= '0;
      phase_r     <= '0;
      side_r      <= 1'b0;
      out_valid_r <= 1'b0;
      enable_r    <= 1'b1;
      phase_inc_r <= 32'd134218;
      depth_r     <= 20'd61440;
      level_r     <= 17'd32768;
    end else begin
      if (state_r == mdc_pkg::ST_CLEAR) clr_idx_r <= clr_idx_r + 1'b1;
      if (in_acc) side_r <= 1'b0;
      else if (state_r == mdc_pkg::ST_INTERP) side_r <= 1'b1;
      if (state_r == mdc_pkg::ST_MIX) begin
        wi_r    <= (wi_r == LAST_IDX) ? '0 : wi_r + 1'b1;
        phase_r <= phase_r + phase_inc_r;
      end
      if (state_r == mdc_pkg::ST_OUT && (!out_valid_r || !out_stall)) out_valid_r <= 1'b1;
      else if (out_take) out_valid_r <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        unique case (mdc_pkg::cfg_idx_t'(cfg_index))
          mdc_pkg::CFG_ENABLE:    enable_r    <= cfg_data[0];
          mdc_pkg::CFG_PHASE_INC: phase_inc_r <= cfg_data;
          mdc_pkg::CFG_DEPTH:     depth_r     <= cfg_data[mdc_pkg::DEPTH_W-1:0];
          mdc_pkg::CFG_LEVEL:     level_r     <= cfg_data[mdc_pkg::LEVEL_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (in_acc) begin
      dry_r   <= in_sample_in;
      res_l_r <= in_sample_in;
      res_r_r <= in_sample_in;
    end
    if (state_r == mdc_pkg::ST_LFO) prod_r <= lfo * depth_r;
    if (state_r == mdc_pkg::ST_DLY) begin
      d_r <= ({{(CW - DW){1'b0}}, d_raw} > DMAX) ? DMAX[PW-1:0] : PW'(d_raw);
    end
    if (state_r == mdc_pkg::ST_ADDR) begin
      p0_r <= rp_fix[PW-1:8];
      f_r  <= rp_fix[7:0];
    end
    if (state_r == mdc_pkg::ST_RD0) p1_r <= (p0_r == LAST_IDX) ? '0 : p0_r + 1'b1;
    if (state_r == mdc_pkg::ST_RD1) x0_r <= ram_rdata;
    if (state_r == mdc_pkg::ST_INTERP) begin
      if (side_r) tap_r_r <= tap_nxt;
      else tap_l_r <= tap_nxt;
    end
    if (state_r == mdc_pkg::ST_MIX) begin
      res_l_r <= mix_out(dry_r, mp_l);
      res_r_r <= mix_out(dry_r, mp_r);
    end
    if (state_r == mdc_pkg::ST_OUT && (!out_valid_r || !out_stall)) begin
      out_left_r  <= res_l_r;
      out_right_r <= res_r_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_left_out  = out_left_r;
  assign out_right_out = out_right_r;

  `MDC_ASSERT_NOW(a_clear_blocks_input, state_r == mdc_pkg::ST_CLEAR, in_stall, "input taken during ram clear")
  `MDC_ASSERT_NEXT(a_bypass_to_out, in_acc && !enable_r, state_r == mdc_pkg::ST_OUT, "bypass transaction did not go to output")
  `MDC_ASSERT_NEXT(a_phase_only_in_mix, state_r != mdc_pkg::ST_MIX, $stable(phase_r) && $stable(wi_r), "lfo phase or write index moved outside mix")
  `MDC_ASSERT_NEXT(a_mul_starts, state_r == mdc_pkg::ST_MUL, busy_l && busy_r, "serial multipliers did not start")

endmodule

[hw/rtl/mdc_ram.sv]
// generic single-write, single-read ram with registered read
module mdc_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 4096,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/mdc_sermul.sv]
// bit-serial signed by unsigned multiplier, one multiplier bit per cycle
module mdc_sermul #(
  parameter int WA = 34,
  parameter int WB = 17
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [WA-1:0]       a,
  input  logic [WB-1:0]       b,
  output logic                busy,
  output logic [WA+WB-1:0]    prod
);

  localparam int CW = $clog2(WB + 1);

  logic [CW-1:0]    cnt_r;
  logic [WA-1:0]    a_r;
  logic [WB-1:0]    b_r;
  logic [WA+WB-1:0] p_r;
  logic [WA+WB-1:0] p_nxt;
  logic [WA-1:0]    upper;
  logic [WA:0]      sum;

  always_comb begin
    upper = p_r[WA+WB-1:WB];
    sum   = {upper[WA-1], upper} + (b_r[0] ? {a_r[WA-1], a_r} : '0);
    p_nxt = {sum, p_r[WB-1:1]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= CW'(WB);
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= a;
      b_r <= b;
      p_r <= '0;
    end else if (cnt_r != '0) begin
      p_r <= p_nxt;
      b_r <= b_r >> 1;
    end
  end

  assign busy = (cnt_r != '0);
  assign prod = p_r;

endmodule
